@@ hdl/hcm_pkg.sv @@
`timescale 1ns / 1ps

package hcm_pkg;

  localparam int MAX_WIDTH_D  = 1024;
  localparam int MAX_HEIGHT_D = 4096;
  localparam int MAX_RADIUS_D = 7;

  localparam logic [10:0] WIDTH_RST     = 11'd512;
  localparam logic [12:0] HEIGHT_RST    = 13'd512;
  localparam logic [2:0]  RADIUS_RST    = 3'd1;
  localparam logic [31:0] THRESHOLD_RST = 32'd500;

  localparam logic [7:0] CORNER_VALUE = 8'hFF;
  localparam int GRAD_SHIFT = 5;

  typedef enum logic [1:0] {
    CFG_WIDTH     = 2'd0,
    CFG_HEIGHT    = 2'd1,
    CFG_RADIUS    = 2'd2,
    CFG_THRESHOLD = 2'd3
  } cfg_idx_t;

endpackage

@@ hdl/harris_corner_marker_top.sv @@
`timescale 1ns / 1ps

// Channel  | Direction | Payload
// in_      | slave     | tdata[7:0] pixel
// out_     | master    | tdata: value, row, col; tuser: corner flag; tlast: frame end
// cfg_     | write     | cfg_index selects width, height, radius or threshold
//
// An interior result is computed with one line-store read port (four reads per window
// pixel) and one shared multiplier; a border result skips the window.
// The output register lets a new item be taken while a result waits; the next result
// stalls until that transfer happens. A register write holds the input off while the
// derived sizes settle. Reset (synchronous, active low) restores the default registers
// and restarts the frame.
module harris_corner_marker_top #(
  parameter int MAX_WIDTH  = hcm_pkg::MAX_WIDTH_D,
  parameter int MAX_HEIGHT = hcm_pkg::MAX_HEIGHT_D,
  parameter int MAX_RADIUS = hcm_pkg::MAX_RADIUS_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] out_value, [19:8] out_row, [29:20] out_col
  output logic        out_tuser,  // [0] is_corner
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int ROWS   = 2 * MAX_RADIUS + 3;
  localparam int SLOT_W = $clog2(ROWS);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int TOT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int T_W    = $clog2(MAX_WIDTH * MAX_HEIGHT + (MAX_RADIUS + 1) * MAX_WIDTH
                                 + MAX_RADIUS + 2);
  localparam int WIN_W  = $clog2(2 * MAX_RADIUS + 1);
  localparam int SUM_W  = $clog2(49 * (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1) + 1;
  localparam int MUL_W  = SUM_W + 1;
  localparam int PRD_W  = 2 * MUL_W;
  localparam int NUM_W  = PRD_W + 6;
  localparam int CMP_W  = (NUM_W > 39) ? NUM_W : 39;
  localparam int ADDR_W = SLOT_W + COL_W;
  localparam int DEPTH  = ROWS * (2 ** COL_W);
  localparam logic signed [CMP_W-1:0] TWENTY = CMP_W'(20);

  typedef enum logic [2:0] {
    S_IDLE, S_CENTER, S_CWAIT, S_GRAD, S_MAC, S_RESP, S_EMIT
  } state_t;

  state_t state_r;
  logic [2:0] ph_r;
  logic [1:0] cfg_hold_r;

  logic [10:0] img_w_r;
  logic [12:0] img_h_r;
  logic [2:0]  img_r_r;
  logic signed [31:0] thr_r;
  logic [WID_W-1:0] w_c_r;
  logic [HGT_W-1:0] h_c_r;
  logic [RAD_W-1:0] r_c_r;
  logic [TOT_W-1:0] total_r;
  logic [T_W-1:0]   lag_r;

  logic [T_W-1:0]    t_r;
  logic [COL_W-1:0]  wcol_r;
  logic [SLOT_W-1:0] wslot_r;
  logic [COL_W-1:0]  ocol_r;
  logic [ROW_W-1:0]  orow_r;
  logic [SLOT_W-1:0] oslot_r;

  logic [SLOT_W-1:0] ys_r;
  logic [COL_W-1:0]  wx_r;
  logic [WIN_W-1:0]  dx_r, dy_r;
  logic [7:0] up_r, dn_r, lf_r, rd_r;
  logic signed [4:0] gx_r, gy_r;
  logic signed [SUM_W-1:0] sxx_r, syy_r, sxy_r;
  logic signed [NUM_W-1:0] det_r, num_r;
  logic [7:0] val_r;
  logic       corner_r;

  logic        out_valid_r;
  logic [7:0]  out_val_r;
  logic        out_corner_r;
  logic [11:0] out_row_r;
  logic [9:0]  out_col_r;
  logic        out_last_r;

  logic [7:0] mem [DEPTH];
  logic [ADDR_W-1:0] raddr;
  logic              accept;
  logic              wen;
  logic              interior;
  logic              frame_last;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PRD_W-1:0] mul_p;
  logic signed [MUL_W-1:0] trace;
  logic signed [4:0]       gy_new;
  logic signed [CMP_W-1:0] k_thr, k20, num_x;
  logic                    hit;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (32'(s) == ROWS - 1) ? '0 : SLOT_W'(s + 1'b1);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    return (s == '0) ? SLOT_W'(ROWS - 1) : SLOT_W'(s - 1'b1);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] s,
                                                  input logic [RAD_W-1:0] r);
    logic [SLOT_W+1:0] tmp;
    tmp = (SLOT_W+2)'(s) + (SLOT_W+2)'(ROWS) - (SLOT_W+2)'(r);
    if (32'(tmp) >= ROWS) tmp = tmp - (SLOT_W+2)'(ROWS);
    return SLOT_W'(tmp);
  endfunction

  // Central difference scaled by 1/32, truncated toward zero.
  function automatic logic signed [4:0] grad(input logic [7:0] a, input logic [7:0] b);
    logic signed [8:0] d;
    logic [8:0] mag;
    logic [4:0] q;
    d   = signed'({1'b0, a}) - signed'({1'b0, b});
    mag = d[8] ? 9'(-d) : 9'(d);
    q   = 5'(mag >> hcm_pkg::GRAD_SHIFT);
    return d[8] ? -signed'(q) : signed'(q);
  endfunction

  // The derived sizes are registered, so the input waits for them after a write.
  assign in_tready = (state_r == S_IDLE) && (cfg_hold_r == '0);
  assign accept    = in_tvalid && in_tready;
  assign wen       = accept && (32'(t_r) < 32'(total_r));

  assign interior = (32'(orow_r) >= 32'(r_c_r) + 1)
                 && (32'(orow_r) + 32'(r_c_r) + 1 < 32'(h_c_r))
                 && (32'(ocol_r) >= 32'(r_c_r) + 1)
                 && (32'(ocol_r) + 32'(r_c_r) + 1 < 32'(w_c_r));
  assign frame_last = (32'(orow_r) == 32'(h_c_r) - 1) && (32'(ocol_r) == 32'(w_c_r) - 1);

  always_comb begin
    raddr = {oslot_r, ocol_r};
    if (state_r == S_GRAD) begin
      case (ph_r)
        3'd0:    raddr = {slot_dec(ys_r), wx_r};
        3'd1:    raddr = {slot_inc(ys_r), wx_r};
        3'd2:    raddr = {ys_r, COL_W'(wx_r - 1'b1)};
        default: raddr = {ys_r, COL_W'(wx_r + 1'b1)};
      endcase
    end
  end

  assign trace  = MUL_W'(sxx_r) + MUL_W'(syy_r);
  assign gy_new = grad(lf_r, rd_r);

  // The one multiplier serves the window sums and the response terms.
  always_comb begin
    mul_a = MUL_W'(gx_r);
    mul_b = MUL_W'(gx_r);
    if (state_r == S_MAC) begin
      case (ph_r)
        3'd0:    begin mul_a = MUL_W'(gx_r); mul_b = MUL_W'(gx_r); end
        3'd1:    begin mul_a = MUL_W'(gy_r); mul_b = MUL_W'(gy_r); end
        default: begin mul_a = MUL_W'(gx_r); mul_b = MUL_W'(gy_r); end
      endcase
    end else begin
      case (ph_r)
        3'd0:    begin mul_a = MUL_W'(sxx_r); mul_b = MUL_W'(syy_r); end
        3'd1:    begin mul_a = MUL_W'(sxy_r); mul_b = MUL_W'(sxy_r); end
        default: begin mul_a = trace;         mul_b = trace;         end
      endcase
    end
  end
  assign mul_p = mul_a * mul_b;

  // trunc(num/20) > thr is the same as num >= 20*(thr+1) for a positive bound,
  // and num > 20*(thr+1) - 20 otherwise.
  assign k_thr = CMP_W'(thr_r) + TWENTY - CMP_W'(19);
  assign k20   = (k_thr <<< 4) + (k_thr <<< 2);
  assign num_x = CMP_W'(num_r);
  assign hit   = (!k_thr[CMP_W-1] && (k_thr != '0)) ? (num_x >= k20) : (num_x > k20 - TWENTY);

  always_ff @(posedge clk) begin
    if (wen) mem[{wslot_r, wcol_r}] <= in_tdata;
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    w_c_r   <= (img_w_r == '0) ? WID_W'(1) :
               (32'(img_w_r) > MAX_WIDTH) ? WID_W'(MAX_WIDTH) : WID_W'(img_w_r);
    h_c_r   <= (img_h_r == '0) ? HGT_W'(1) :
               (32'(img_h_r) > MAX_HEIGHT) ? HGT_W'(MAX_HEIGHT) : HGT_W'(img_h_r);
    r_c_r   <= (32'(img_r_r) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(img_r_r);
    total_r <= TOT_W'(32'(w_c_r) * 32'(h_c_r));
    lag_r   <= T_W'((32'(r_c_r) + 1) * 32'(w_c_r) + 32'(r_c_r) + 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= '0;
      cfg_hold_r  <= 2'd2;
      img_w_r     <= hcm_pkg::WIDTH_RST;
      img_h_r     <= hcm_pkg::HEIGHT_RST;
      img_r_r     <= hcm_pkg::RADIUS_RST;
      thr_r       <= hcm_pkg::THRESHOLD_RST;
      t_r         <= '0;
      wcol_r      <= '0;
      wslot_r     <= '0;
      ocol_r      <= '0;
      orow_r      <= '0;
      oslot_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (cfg_wr_en || state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_wr_en) begin
        cfg_hold_r <= 2'd2;
      end else if (cfg_hold_r != '0) begin
        cfg_hold_r <= cfg_hold_r - 2'd1;
      end

      if (cfg_wr_en) begin
        case (hcm_pkg::cfg_idx_t'(cfg_index))
          hcm_pkg::CFG_WIDTH:     img_w_r <= cfg_wdata[10:0];
          hcm_pkg::CFG_HEIGHT:    img_h_r <= cfg_wdata[12:0];
          hcm_pkg::CFG_RADIUS:    img_r_r <= cfg_wdata[2:0];
          hcm_pkg::CFG_THRESHOLD: thr_r   <= cfg_wdata;
          default: ;
        endcase
        t_r     <= '0;
        wcol_r  <= '0;
        wslot_r <= '0;
        ocol_r  <= '0;
        orow_r  <= '0;
        oslot_r <= '0;
      end else begin
        case (state_r)
          S_IDLE: begin
            if (accept) begin
              t_r <= T_W'(t_r + 1'b1);
              if (wen) begin
                if (32'(wcol_r) == 32'(w_c_r) - 1) begin
                  wcol_r  <= '0;
                  wslot_r <= slot_inc(wslot_r);
                end else begin
                  wcol_r <= COL_W'(wcol_r + 1'b1);
                end
              end
              if (t_r >= lag_r) state_r <= S_CENTER;
            end
          end
          S_CENTER: state_r <= S_CWAIT;
          S_CWAIT: begin
            val_r    <= rd_r >> 2;
            corner_r <= 1'b0;
            sxx_r    <= '0;
            syy_r    <= '0;
            sxy_r    <= '0;
            ys_r     <= slot_back(oslot_r, r_c_r);
            wx_r     <= COL_W'(ocol_r - COL_W'(r_c_r));
            dx_r     <= '0;
            dy_r     <= '0;
            ph_r     <= '0;
            state_r  <= interior ? S_GRAD : S_EMIT;
          end
          S_GRAD: begin
            case (ph_r)
              3'd1: up_r <= rd_r;
              3'd2: dn_r <= rd_r;
              3'd3: lf_r <= rd_r;
              default: ;
            endcase
            if (ph_r == 3'd4) begin
              gx_r    <= grad(up_r, dn_r);
              gy_r    <= gy_new;
              ph_r    <= '0;
              state_r <= S_MAC;
            end else begin
              ph_r <= ph_r + 3'd1;
            end
          end
          S_MAC: begin
            case (ph_r)
              3'd0:    sxx_r <= sxx_r + SUM_W'(mul_p);
              3'd1:    syy_r <= syy_r + SUM_W'(mul_p);
              default: sxy_r <= sxy_r + SUM_W'(mul_p);
            endcase
            if (ph_r == 3'd2) begin
              ph_r <= '0;
              if (32'(dx_r) == 2 * 32'(r_c_r)) begin
                dx_r <= '0;
                wx_r <= COL_W'(ocol_r - COL_W'(r_c_r));
                if (32'(dy_r) == 2 * 32'(r_c_r)) begin
                  state_r <= S_RESP;
                end else begin
                  dy_r    <= WIN_W'(dy_r + 1'b1);
                  ys_r    <= slot_inc(ys_r);
                  state_r <= S_GRAD;
                end
              end else begin
                dx_r    <= WIN_W'(dx_r + 1'b1);
                wx_r    <= COL_W'(wx_r + 1'b1);
                state_r <= S_GRAD;
              end
            end else begin
              ph_r <= ph_r + 3'd1;
            end
          end
          S_RESP: begin
            case (ph_r)
              3'd0: det_r <= NUM_W'(mul_p);
              3'd1: det_r <= det_r - NUM_W'(mul_p);
              3'd2: num_r <= (det_r <<< 4) + (det_r <<< 2) - NUM_W'(mul_p);
              default: begin
                corner_r <= hit;
                if (hit) val_r <= hcm_pkg::CORNER_VALUE;
                state_r  <= S_EMIT;
              end
            endcase
            ph_r <= ph_r + 3'd1;
          end
          S_EMIT: begin
            if (!out_valid_r || out_tready) begin
              out_valid_r  <= 1'b1;
              out_val_r    <= val_r;
              out_corner_r <= corner_r;
              out_row_r    <= 12'(orow_r);
              out_col_r    <= 10'(ocol_r);
              out_last_r   <= frame_last;
              state_r      <= S_IDLE;
              if (frame_last) begin
                t_r     <= '0;
                wcol_r  <= '0;
                wslot_r <= '0;
                ocol_r  <= '0;
                orow_r  <= '0;
                oslot_r <= '0;
              end else if (32'(ocol_r) == 32'(w_c_r) - 1) begin
                ocol_r  <= '0;
                orow_r  <= ROW_W'(orow_r + 1'b1);
                oslot_r <= slot_inc(oslot_r);
              end else begin
                ocol_r <= COL_W'(ocol_r + 1'b1);
              end
            end
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_col_r, out_row_r, out_val_r};
  assign out_tuser  = out_corner_r;
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  a_corner_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[7:0] == hcm_pkg::CORNER_VALUE)
    else $error("corner transfer without the corner value");

  a_window_col: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GRAD |-> 32'(wx_r) + 1 < 32'(w_c_r) && wx_r != '0)
    else $error("window column left the interior");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && !cfg_wr_en && (!out_valid_r || out_tready)
      |=> state_r == S_IDLE && out_tvalid)
    else $error("result not loaded into the output register");
`endif

endmodule
